// File: design/tpe_pkg.sv
// ----------------------------------------------------------------------------
// Tracking payload encoder package
// Field widths and coding constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package tpe_pkg;

    localparam int LAT_W     = 28;
    localparam int LON_W     = 29;
    localparam int CODE_W    = 24;
    localparam int ALT_W     = 16;
    localparam int KIND_W    = 3;
    localparam int SPEED_W   = 14;
    localparam int HEADING_W = 16;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;

    // Coordinate scale factors (codes per degree).
    localparam int unsigned LAT_SCALE = 93206;
    localparam int unsigned LON_SCALE = 46603;

    // Signed 24-bit code limits, as magnitudes.
    localparam int unsigned CODE_POS_MAX = 8388607;
    localparam int unsigned CODE_NEG_MAG = 8388608;

    // Type word layout.
    localparam logic [10:0] ALT_FIELD_MAX = 11'h7FF;

    // Speed coding.
    localparam logic [SPEED_W-1:0] SPEED_DIRECT_MAX = 14'd2032;
    localparam logic [SPEED_W:0]   SPEED_ROUND      = 15'd8;
    localparam logic [8:0]         SPEED_SCALED_BASE = 9'h080;
    localparam logic [8:0]         BYTE_MAX9        = 9'h0FF;
    // floor(r / 5) = (r * 1639) >> 13 for every r below 2048.
    localparam logic [21:0]        DIV5_RECIP       = 22'd1639;
    localparam int                 DIV5_SHIFT       = 13;

    // Heading coding: floor((hdg * 255 + 23040) / 46080).
    localparam logic [23:0] HDG_ROUND  = 24'd23040;
    localparam logic [48:0] HDG_RECIP  = 49'd23860930;
    localparam int          HDG_SHIFT  = 40;

    localparam logic [BYTE_W-1:0] CLIMB_CODE = 8'h00;

endpackage

// File: design/tracking_payload_encoder.sv
// ----------------------------------------------------------------------------
// Tracking payload encoder: one position report in, one packed payload out.
// Path: an accepted input beat is held in the input register, then its result in the result register.
// Throughput: 1 beat per cycle while out_stall is low, set by the input and result register stages.
// Reset: rst_n clears both stage valid flags; no beat is held after reset.
// ----------------------------------------------------------------------------
module tracking_payload_encoder #(
    parameter int COORD_FRAC_BITS = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tpe_pkg::LAT_W-1:0]     latitude,
    input  logic signed [tpe_pkg::LON_W-1:0]     longitude,
    input  logic [tpe_pkg::ALT_W-1:0]            altitude_m,
    input  logic [tpe_pkg::KIND_W-1:0]           craft_kind,
    input  logic [tpe_pkg::SPEED_W-1:0]          speed_q4,
    input  logic [tpe_pkg::HEADING_W-1:0]        heading_q7,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tpe_pkg::CODE_W-1:0]    lat_code,
    output logic signed [tpe_pkg::CODE_W-1:0]    lon_code,
    output logic [tpe_pkg::WORD_W-1:0]           type_word,
    output logic [tpe_pkg::BYTE_W-1:0]           speed_byte,
    output logic [tpe_pkg::BYTE_W-1:0]           climb_byte,
    output logic [tpe_pkg::BYTE_W-1:0]           heading_byte
);
    import tpe_pkg::*;

    logic in_accept;
    logic res_advance;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    logic signed [LAT_W-1:0] latitude_reg;
    logic signed [LON_W-1:0] longitude_reg;
    logic [ALT_W-1:0]        altitude_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [SPEED_W-1:0]      speed_reg;
    logic [HEADING_W-1:0]    heading_reg;

    logic signed [CODE_W-1:0] lat_calc;
    logic signed [CODE_W-1:0] lon_calc;
    logic [WORD_W-1:0]        type_calc;
    logic [BYTE_W-1:0]        speed_calc;
    logic [BYTE_W-1:0]        heading_calc;

    logic signed [CODE_W-1:0] lat_code_reg;
    logic signed [CODE_W-1:0] lon_code_reg;
    logic [WORD_W-1:0]        type_word_reg;
    logic [BYTE_W-1:0]        speed_byte_reg;
    logic [BYTE_W-1:0]        heading_byte_reg;

    // The result register moves whenever it is empty or its beat is taken.
    assign res_advance = !out_valid_reg || !out_stall;
    assign in_stall    = s1_valid_reg && !res_advance;
    assign in_accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = in_accept || (s1_valid_reg && !res_advance);
        out_valid_next = res_advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            latitude_reg  <= latitude;
            longitude_reg <= longitude;
            altitude_reg  <= altitude_m;
            kind_reg      <= craft_kind;
            speed_reg     <= speed_q4;
            heading_reg   <= heading_q7;
        end
    end

    tpe_coord_scale #(
        .IN_W      (LAT_W),
        .SCALE     (LAT_SCALE),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_lat_scale (
        .raw  (latitude_reg),
        .code (lat_calc)
    );

    tpe_coord_scale #(
        .IN_W      (LON_W),
        .SCALE     (LON_SCALE),
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_lon_scale (
        .raw  (longitude_reg),
        .code (lon_calc)
    );

    tpe_field_pack u_field_pack (
        .altitude_m   (altitude_reg),
        .craft_kind   (kind_reg),
        .speed_q4     (speed_reg),
        .heading_q7   (heading_reg),
        .type_word    (type_calc),
        .speed_byte   (speed_calc),
        .heading_byte (heading_calc)
    );

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && res_advance)
        begin
            lat_code_reg     <= lat_calc;
            lon_code_reg     <= lon_calc;
            type_word_reg    <= type_calc;
            speed_byte_reg   <= speed_calc;
            heading_byte_reg <= heading_calc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lat_code     = lat_code_reg;
    assign lon_code     = lon_code_reg;
    assign type_word    = type_word_reg;
    assign speed_byte   = speed_byte_reg;
    assign climb_byte   = CLIMB_CODE;
    assign heading_byte = heading_byte_reg;

    // A result can only appear when the input stage held a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a beat in the input stage");

    // A beat held in the input stage is never dropped while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !res_advance |=> s1_valid_reg && out_valid_reg)
        else $error("stalled beat lost from the input stage");

    // Every delivered type word carries the online bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> type_word_reg[WORD_W-1])
        else $error("online bit missing from type word");

    // A scaled altitude is always at least 512 in units of 4 m.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && type_word_reg[11] |-> type_word_reg[10:9] != 2'b00)
        else $error("scaled altitude field below its lower bound");

endmodule

// File: design/tpe_coord_scale.sv
// ----------------------------------------------------------------------------
// Coordinate scaler
// Multiplies a signed fixed-point coordinate by a constant, rounds half away
// from zero and saturates the result to a signed 24-bit code.
// ----------------------------------------------------------------------------
module tpe_coord_scale #(
    parameter int IN_W      = 28,
    parameter int SCALE     = 93206,
    parameter int FRAC_BITS = 20
) (
    input  logic signed [IN_W-1:0]           raw,
    output logic signed [tpe_pkg::CODE_W-1:0] code
);
    import tpe_pkg::*;

    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int PROD_W  = IN_W + SCALE_W + 1;

    logic              neg;
    logic [IN_W-1:0]   mag;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rounded;
    logic [PROD_W-1:0] quo;

    // Work on the magnitude so that rounding is symmetric about zero.
    assign neg     = raw[IN_W-1];
    assign mag     = neg ? (~raw + 1'b1) : raw;
    assign prod    = PROD_W'(mag) * PROD_W'(SCALE);
    assign rounded = prod + (PROD_W'(1) << (FRAC_BITS - 1));
    assign quo     = rounded >> FRAC_BITS;

    always_comb
    begin
        if (neg)
        begin
            if (quo > PROD_W'(CODE_NEG_MAG))
            begin
                code = CODE_W'(CODE_NEG_MAG);
            end
            else
            begin
                code = ~quo[CODE_W-1:0] + 1'b1;
            end
        end
        else
        begin
            if (quo > PROD_W'(CODE_POS_MAX))
            begin
                code = CODE_W'(CODE_POS_MAX);
            end
            else
            begin
                code = quo[CODE_W-1:0];
            end
        end
    end

endmodule

// File: design/tpe_field_pack.sv
// ----------------------------------------------------------------------------
// Field packer
// Builds the type word and codes the speed and heading into single bytes.
// ----------------------------------------------------------------------------
module tpe_field_pack (
    input  logic [tpe_pkg::ALT_W-1:0]     altitude_m,
    input  logic [tpe_pkg::KIND_W-1:0]    craft_kind,
    input  logic [tpe_pkg::SPEED_W-1:0]   speed_q4,
    input  logic [tpe_pkg::HEADING_W-1:0] heading_q7,
    output logic [tpe_pkg::WORD_W-1:0]    type_word,
    output logic [tpe_pkg::BYTE_W-1:0]    speed_byte,
    output logic [tpe_pkg::BYTE_W-1:0]    heading_byte
);
    import tpe_pkg::*;

    logic        alt_scaled;
    logic [13:0] alt_quarter;
    logic [10:0] alt_field;

    logic [SPEED_W:0] spd_sum;
    logic [10:0]      spd_round;
    logic [21:0]      spd_prod;
    logic [8:0]       spd_div5;
    logic [8:0]       spd_scaled;

    logic [23:0] hdg_num;
    logic [48:0] hdg_prod;
    logic [8:0]  hdg_quo;

    // Altitude: direct up to the field limit, otherwise in units of 4 m.
    assign alt_scaled  = altitude_m > ALT_W'(ALT_FIELD_MAX);
    assign alt_quarter = altitude_m[ALT_W-1:2];

    always_comb
    begin
        if (!alt_scaled)
        begin
            alt_field = altitude_m[10:0];
        end
        else if (alt_quarter > 14'(ALT_FIELD_MAX))
        begin
            alt_field = ALT_FIELD_MAX;
        end
        else
        begin
            alt_field = alt_quarter[10:0];
        end
    end

    assign type_word = {1'b1, craft_kind, alt_scaled, alt_field};

    // Speed: the range test uses the unrounded value.
    assign spd_sum    = {1'b0, speed_q4} + SPEED_ROUND;
    assign spd_round  = spd_sum[SPEED_W:4];
    assign spd_prod   = 22'(spd_round) * DIV5_RECIP;
    assign spd_div5   = spd_prod[DIV5_SHIFT+8:DIV5_SHIFT];
    assign spd_scaled = SPEED_SCALED_BASE + spd_div5;

    always_comb
    begin
        if (speed_q4 <= SPEED_DIRECT_MAX)
        begin
            speed_byte = spd_round[BYTE_W-1:0];
        end
        else if (spd_scaled > BYTE_MAX9)
        begin
            speed_byte = BYTE_MAX9[BYTE_W-1:0];
        end
        else
        begin
            speed_byte = spd_scaled[BYTE_W-1:0];
        end
    end

    // Heading: hdg * 255 is formed as a shift and subtract, the division by
    // 46080 as a multiply by its scaled reciprocal.
    assign hdg_num  = {heading_q7, 8'h00} - 24'(heading_q7) + HDG_ROUND;
    assign hdg_prod = 49'(hdg_num) * HDG_RECIP;
    assign hdg_quo  = hdg_prod[HDG_SHIFT+8:HDG_SHIFT];

    assign heading_byte = (hdg_quo > BYTE_MAX9) ? BYTE_MAX9[BYTE_W-1:0]
                                                : hdg_quo[BYTE_W-1:0];

endmodule

// File: sim/tracking_payload_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking payload encoder testbench
// Sends position reports through the encoder and compares every packed
// payload, field by field, against an independent encoding of each report.
// Directed reports cover coordinate, altitude, speed and heading corners;
// random reports follow under input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tracking_payload_encoder_test;

    import tpe_pkg::*;

    localparam int FRAC_BITS    = 20;
    localparam int LAT_LIMIT    = 94371840;    // 90 degrees
    localparam int LON_LIMIT    = 188743680;   // 180 degrees
    localparam int FULL_TURN_Q7 = 46080;
    localparam int ALT_DIRECT   = 2047;
    localparam int SPEED_KNEE   = 2032;

    typedef struct packed {
        logic [LAT_W-1:0]     latitude;
        logic [LON_W-1:0]     longitude;
        logic [ALT_W-1:0]     altitude;
        logic [KIND_W-1:0]    kind;
        logic [SPEED_W-1:0]   speed;
        logic [HEADING_W-1:0] heading;
    } report_t;

    typedef struct packed {
        logic [CODE_W-1:0] lat_code;
        logic [CODE_W-1:0] lon_code;
        logic [WORD_W-1:0] type_word;
        logic [BYTE_W-1:0] speed_byte;
        logic [BYTE_W-1:0] climb_byte;
        logic [BYTE_W-1:0] heading_byte;
    } payload_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [LAT_W-1:0]     latitude;
    logic signed [LON_W-1:0]     longitude;
    logic [ALT_W-1:0]            altitude_m;
    logic [KIND_W-1:0]           craft_kind;
    logic [SPEED_W-1:0]          speed_q4;
    logic [HEADING_W-1:0]        heading_q7;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [CODE_W-1:0]    lat_code;
    logic signed [CODE_W-1:0]    lon_code;
    logic [WORD_W-1:0]           type_word;
    logic [BYTE_W-1:0]           speed_byte;
    logic [BYTE_W-1:0]           climb_byte;
    logic [BYTE_W-1:0]           heading_byte;

    payload_t expected_payloads[$];
    int       reports_sent;
    int       payloads_checked;
    int       mismatches;
    int       burst_left;
    bit       tx_gaps_on;
    bit       rx_stall_on;

    tracking_payload_encoder #(
        .COORD_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .latitude     (latitude),
        .longitude    (longitude),
        .altitude_m   (altitude_m),
        .craft_kind   (craft_kind),
        .speed_q4     (speed_q4),
        .heading_q7   (heading_q7),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .lat_code     (lat_code),
        .lon_code     (lon_code),
        .type_word    (type_word),
        .speed_byte   (speed_byte),
        .climb_byte   (climb_byte),
        .heading_byte (heading_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Degrees in fixed point times codes per degree, rounded half away from
    // zero and clamped to the signed 24-bit code range.
    function automatic logic [CODE_W-1:0] scale_degrees(longint deg_fx, longint per_degree);
        longint magnitude;
        longint code;
        magnitude = (deg_fx < 0) ? -deg_fx : deg_fx;
        code = (magnitude * per_degree + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (deg_fx < 0)
            code = (code > 8388608) ? -8388608 : -code;
        else if (code > 8388607)
            code = 8388607;
        return code[CODE_W-1:0];
    endfunction

    function automatic payload_t encode_report(report_t r);
        payload_t p;
        int       alt_code;
        int       rounded;
        int       code;
        p.lat_code = scale_degrees(longint'($signed(r.latitude)), 93206);
        p.lon_code = scale_degrees(longint'($signed(r.longitude)), 46603);

        if (r.altitude > ALT_DIRECT)
        begin
            alt_code = r.altitude / 4;
            if (alt_code > ALT_DIRECT)
                alt_code = ALT_DIRECT;
            p.type_word = {1'b1, r.kind, 1'b1, alt_code[10:0]};
        end
        else
        begin
            p.type_word = {1'b1, r.kind, 1'b0, r.altitude[10:0]};
        end

        // The knee compares the unrounded speed, so 127.0625 already scales.
        rounded = (int'(r.speed) + 8) >> 4;
        if (r.speed > SPEED_KNEE)
        begin
            code = 128 + rounded / 5;
            if (code > 255)
                code = 255;
        end
        else
        begin
            code = rounded;
        end
        p.speed_byte = code[7:0];
        p.climb_byte = '0;

        code = (int'(r.heading) * 255 + FULL_TURN_Q7 / 2) / FULL_TURN_Q7;
        if (code > 255)
            code = 255;
        p.heading_byte = code[7:0];
        return p;
    endfunction

    function automatic report_t random_report();
        report_t r;
        int      pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            r.latitude = LAT_W'(int'($urandom_range(0, 2 * LAT_LIMIT)) - LAT_LIMIT);
        else if (pick < 8)
            r.latitude = LAT_W'($urandom());
        else
            r.latitude = LAT_W'(int'($urandom_range(0, 8192)) - 4096);

        pick = $urandom_range(0, 9);
        if (pick < 6)
            r.longitude = LON_W'(int'($urandom_range(0, 2 * LON_LIMIT)) - LON_LIMIT);
        else if (pick < 8)
            r.longitude = LON_W'($urandom());
        else
            r.longitude = LON_W'(int'($urandom_range(0, 8192)) - 4096);

        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.altitude = ALT_W'($urandom_range(0, ALT_DIRECT));
        else if (pick == 4)
            r.altitude = ALT_W'($urandom_range(2040, 2056));
        else if (pick == 5)
            r.altitude = ALT_W'($urandom_range(8184, 8200));
        else
            r.altitude = ALT_W'($urandom_range(0, 65535));

        r.kind = KIND_W'($urandom_range(0, 7));

        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.speed = SPEED_W'($urandom_range(0, SPEED_KNEE));
        else if (pick == 4)
            r.speed = SPEED_W'($urandom_range(2024, 2044));
        else if (pick == 5)
            r.speed = SPEED_W'($urandom_range(10220, 10245));
        else
            r.speed = SPEED_W'($urandom_range(0, 16383));

        pick = $urandom_range(0, 9);
        if (pick < 7)
            r.heading = HEADING_W'($urandom_range(0, FULL_TURN_Q7));
        else if (pick == 7)
            r.heading = HEADING_W'($urandom_range(46070, 46090));
        else
            r.heading = HEADING_W'($urandom_range(0, 65535));
        return r;
    endfunction

    // Sender: bursts of back-to-back beats separated by idle gaps when enabled.
    task automatic send_report(report_t r);
        int gap;
        if (tx_gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid   <= 1'b1;
        latitude   <= r.latitude;
        longitude  <= r.longitude;
        altitude_m <= r.altitude;
        craft_kind <= r.kind;
        speed_q4   <= r.speed;
        heading_q7 <= r.heading;
        do
            @(posedge clk);
        while (in_stall);
        expected_payloads.push_back(encode_report(r));
        reports_sent++;
    endtask

    // Receiver: alternating free and stalled runs of random length.
    initial
    begin
        int run;
        bit holding;
        out_stall = 1'b0;
        run       = 0;
        holding   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rx_stall_on)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (run == 0)
                begin
                    holding = !holding;
                    run = holding ? $urandom_range(1, 6) : $urandom_range(1, 20);
                end
                out_stall <= holding;
                run--;
            end
        end
    end

    task automatic compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        payload_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_payloads.size() == 0)
            begin
                $error("payload beat with no report outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_payloads.pop_front();
                compare_field("lat_code", longint'($signed(want.lat_code)),
                              longint'(lat_code));
                compare_field("lon_code", longint'($signed(want.lon_code)),
                              longint'(lon_code));
                compare_field("type_word", longint'(want.type_word), longint'(type_word));
                compare_field("speed_byte", longint'(want.speed_byte),
                              longint'(speed_byte));
                compare_field("climb_byte", longint'(want.climb_byte),
                              longint'(climb_byte));
                compare_field("heading_byte", longint'(want.heading_byte),
                              longint'(heading_byte));
                payloads_checked++;
            end
        end
    end

    task automatic test_coordinates();
        report_t r;
        int      lat_vals[7];
        int      lon_vals[7];
        // Full-scale inputs, the plus and minus 90/180 degree limits, and the
        // exact half-code points that must round away from zero.
        lat_vals = '{134217727, -134217728, LAT_LIMIT, -LAT_LIMIT, 262144, -262144, 0};
        lon_vals = '{268435455, -268435456, LON_LIMIT, -LON_LIMIT, 524288, -524288, 0};
        foreach (lat_vals[i])
        begin
            r = random_report();
            r.latitude  = LAT_W'(lat_vals[i]);
            r.longitude = LON_W'(lon_vals[i]);
            send_report(r);
        end
    endtask

    task automatic test_altitude();
        report_t r;
        int      alts[6];
        alts = '{0, 2047, 2048, 8191, 8192, 65535};
        foreach (alts[i])
        begin
            r = random_report();
            r.altitude = ALT_W'(alts[i]);
            r.kind     = KIND_W'(i);
            send_report(r);
        end
    endtask

    task automatic test_speed();
        report_t r;
        int      speeds[7];
        // Around the scaling knee and where the scaled byte starts to saturate at 0xFF.
        speeds = '{0, 8, 2032, 2033, 10231, 10232, 16383};
        foreach (speeds[i])
        begin
            r = random_report();
            r.speed = SPEED_W'(speeds[i]);
            r.kind  = KIND_W'(6 + (i % 2));
            send_report(r);
        end
    endtask

    task automatic test_heading();
        report_t r;
        int      headings[5];
        headings = '{0, 91, 46080, 46081, 65535};
        rx_stall_on = 1'b1;
        foreach (headings[i])
        begin
            r = random_report();
            r.heading = HEADING_W'(headings[i]);
            send_report(r);
        end
    endtask

    task automatic test_random();
        rx_stall_on = 1'b0;
        tx_gaps_on  = 1'b0;
        repeat (150)
            send_report(random_report());
        rx_stall_on = 1'b1;
        tx_gaps_on  = 1'b1;
        repeat (300)
            send_report(random_report());
        tx_gaps_on = 1'b0;
        repeat (250)
            send_report(random_report());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        latitude         = '0;
        longitude        = '0;
        altitude_m       = '0;
        craft_kind       = '0;
        speed_q4         = '0;
        heading_q7       = '0;
        reports_sent     = 0;
        payloads_checked = 0;
        mismatches       = 0;
        burst_left       = 0;
        tx_gaps_on       = 1'b0;
        rx_stall_on      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_coordinates();
        test_altitude();
        test_speed();
        test_heading();
        test_random();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_payloads.size() != 0)
            @(posedge clk);
        // Any stray beat after the last expected one shows up in this window.
        repeat (10) @(posedge clk);

        $display("Encoded %0d position reports (coordinate, altitude, speed and heading",
                 reports_sent);
        $display("corners plus random reports under gaps and stalls); %0d payloads checked.",
                 payloads_checked);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: tracking_payload_encoder.f
design/tpe_pkg.sv
design/tpe_coord_scale.sv
design/tpe_field_pack.sv
design/tracking_payload_encoder.sv
sim/tracking_payload_encoder_test.sv
